>>> rtl/rfle_pkg.sv
// types, character codes and helpers shared by the receive fifo line editor
package rfle_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int LINE_AW    = 6;
	localparam int LINE_CAP   = 63;

	localparam logic [1:0] OP_RX   = 2'd0;
	localparam logic [1:0] OP_TAKE = 2'd1;
	localparam logic [1:0] OP_LINE = 2'd2;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_TAKE,
		S_TAKE_EV,
		S_LN_CHK,
		S_LN_EV,
		S_PK_CHK,
		S_PK_EV,
		S_EM_RD,
		S_EM_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} fifo_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic has_line;
	} fifo_sts_t;

	typedef struct packed {
		logic               wr;
		logic               rd;
		logic [LINE_AW-1:0] wr_addr;
		logic [LINE_AW-1:0] rd_addr;
	} line_cmd_t;

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_bs(input logic [7:0] c);
		return (c == CH_BS) || (c == CH_DEL);
	endfunction

	function automatic logic is_pair(input logic [7:0] t, input logic [7:0] c);
		return ((t == CH_CR) && (c == CH_LF)) || ((t == CH_LF) && (c == CH_CR));
	endfunction

endpackage

>>> rtl/rfle_fifo.sv
// receive ring fifo: byte memory, indices and terminator count
module rfle_fifo import rfle_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_cmd_t  cmd,
	input  logic [7:0] push_byte,
	output fifo_sts_t  sts,
	output logic [7:0] rd_data
);

	localparam int IW = $clog2(FIFO_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);

	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rd_data_q;
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] term_cnt_q;
	logic [IW-1:0] wr_nxt;
	logic [IW-1:0] rd_nxt;

	assign wr_nxt = (wr_idx_q == LAST_IDX) ? '0 : IW'(wr_idx_q + 1'b1);
	assign rd_nxt = (rd_idx_q == LAST_IDX) ? '0 : IW'(rd_idx_q + 1'b1);

	assign sts.empty    = (wr_idx_q == rd_idx_q);
	assign sts.full     = (wr_nxt == rd_idx_q);
	assign sts.has_line = (term_cnt_q != '0);
	assign rd_data      = rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wr_idx_q] <= push_byte;
		if (cmd.rd)
			rd_data_q <= mem[rd_idx_q];
	end

	// a pop always follows a read of the head, so rd_data_q is the byte leaving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			term_cnt_q <= '0;
		end else begin
			if (cmd.push && !sts.full) begin
				wr_idx_q <= wr_nxt;
				if (is_term(push_byte))
					term_cnt_q <= IW'(term_cnt_q + 1'b1);
			end else if (cmd.pop) begin
				rd_idx_q <= rd_nxt;
				if (is_term(rd_data_q) && term_cnt_q != '0)
					term_cnt_q <= IW'(term_cnt_q - 1'b1);
			end
		end
	end

endmodule

>>> rtl/rfle_line_buf.sv
// scratch memory for the line being edited
module rfle_line_buf import rfle_pkg::*; (
	input  logic       clk,
	input  line_cmd_t  cmd,
	input  logic [7:0] wr_data,
	output logic [7:0] rd_data
);

	logic [7:0] mem [LINE_DEPTH];
	logic [7:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[cmd.wr_addr] <= wr_data;
		if (cmd.rd)
			rd_data_q <= mem[cmd.rd_addr];
	end

endmodule

>>> rtl/receive_fifo_line_editor.sv
// receive fifo with line editing: top level sequencer and result register
//
// Input request: op and rx_byte under in_valid/in_stall. op 0 stores a
// received byte (echoed, or flagged dropped when the fifo is full), op 1
// takes one byte, op 2 takes one edited line, op 3 does nothing.
// Output request: one result per op 0, 1 or 3; one result per kept character
// for op 2 (a single empty result when nothing is kept), last marks the end.
// One item is in work at a time; in_stall is high until its last result has
// been loaded into the output register, and the next request is taken in
// the cycle after, so no new request is taken while an item is in work.
// A line read pops each fifo byte by a memory read, then a classify step,
// looks for the end (peeking at the byte after a terminator), then returns
// each kept character by a line memory read, then an output step, or gives
// the single empty result. The single registered read port of each memory
// sets these steps.
// When out_stall holds the output register, the sequencer waits in place;
// a new request can still be accepted while a result waits to be taken.
// Reset empties the fifo and drops any result in flight; no clearing pass.
module receive_fifo_line_editor import rfle_pkg::*; #(
	parameter int FIFO_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] echo_byte,
	output logic       echo_valid,
	output logic       dropped,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic [5:0] line_length,
	output logic       last,
	output logic       has_data,
	output logic       has_line
);

	localparam int LMAX = ((FIFO_DEPTH - 1) < LINE_CAP) ? (FIFO_DEPTH - 1) : LINE_CAP;
	localparam logic [LINE_AW-1:0] LINE_MAX = LINE_AW'(LMAX);

	state_t             state_q;
	state_t             state_nxt;
	state_t             end_nxt;
	fifo_cmd_t          fcmd;
	fifo_sts_t          fsts;
	line_cmd_t          lcmd;
	logic [7:0]         fifo_rd;
	logic [7:0]         line_rd;
	logic               out_free;
	logic               load_single;
	logic               load_line;
	logic               em_last;

	logic [7:0]         rx_q;
	logic               echo_v_q;
	logic               drop_q;
	logic [7:0]         data_q;
	logic               dvalid_q;
	logic [LINE_AW-1:0] n_q;
	logic [LINE_AW-1:0] k_q;
	logic [7:0]         term_q;

	logic               out_valid_q;
	logic [7:0]         echo_byte_q;
	logic               echo_valid_q;
	logic               dropped_q;
	logic [7:0]         data_byte_q;
	logic               data_valid_q;
	logic [5:0]         line_length_q;
	logic               last_q;
	logic               has_data_q;
	logic               has_line_q;

	rfle_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fcmd),
		.push_byte (rx_q),
		.sts       (fsts),
		.rd_data   (fifo_rd)
	);

	rfle_line_buf u_line (
		.clk     (clk),
		.cmd     (lcmd),
		.wr_data (fifo_rd),
		.rd_data (line_rd)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign em_last  = (LINE_AW'(k_q + 1'b1) == n_q);
	assign end_nxt  = (n_q == '0) ? S_DONE : S_EM_RD;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_RX:   state_nxt = S_PUSH;
						OP_TAKE: state_nxt = S_TAKE;
						OP_LINE: state_nxt = S_LN_CHK;
						default: state_nxt = S_DONE;
					endcase
				end
			end
			S_PUSH:    state_nxt = S_DONE;
			S_TAKE:    state_nxt = fsts.empty ? S_DONE : S_TAKE_EV;
			S_TAKE_EV: state_nxt = S_DONE;
			S_LN_CHK:  state_nxt = (fsts.empty || n_q == LINE_MAX) ? end_nxt : S_LN_EV;
			S_LN_EV:   state_nxt = is_term(fifo_rd) ? S_PK_CHK : S_LN_CHK;
			S_PK_CHK:  state_nxt = fsts.empty ? end_nxt : S_PK_EV;
			S_PK_EV:   state_nxt = end_nxt;
			S_EM_RD:   state_nxt = S_EM_OUT;
			S_EM_OUT: begin
				if (out_free)
					state_nxt = em_last ? S_IDLE : S_EM_RD;
			end
			S_DONE: begin
				if (out_free)
					state_nxt = S_IDLE;
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		fcmd         = '0;
		lcmd         = '0;
		lcmd.wr_addr = n_q;
		lcmd.rd_addr = k_q;
		load_single  = 1'b0;
		load_line    = 1'b0;
		in_stall     = 1'b1;
		unique case (state_q)
			S_IDLE:    in_stall = 1'b0;
			S_PUSH:    fcmd.push = !fsts.full;
			S_TAKE:    fcmd.rd = !fsts.empty;
			S_TAKE_EV: fcmd.pop = 1'b1;
			S_LN_CHK:  fcmd.rd = !fsts.empty && (n_q != LINE_MAX);
			S_LN_EV: begin
				fcmd.pop = 1'b1;
				lcmd.wr  = !is_term(fifo_rd) && !is_bs(fifo_rd);
			end
			S_PK_CHK:  fcmd.rd = !fsts.empty;
			// drop the other half of a cr/lf pair
			S_PK_EV:   fcmd.pop = is_pair(term_q, fifo_rd);
			S_EM_RD:   lcmd.rd = 1'b1;
			S_EM_OUT:  load_line = out_free;
			S_DONE:    load_single = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_single || load_line)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// working registers of the item in progress
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rx_q     <= rx_byte;
					echo_v_q <= (op == OP_RX);
					drop_q   <= 1'b0;
					data_q   <= '0;
					dvalid_q <= 1'b0;
					n_q      <= '0;
					k_q      <= '0;
				end
			end
			S_PUSH: drop_q <= fsts.full;
			S_TAKE_EV: begin
				data_q   <= fifo_rd;
				dvalid_q <= 1'b1;
			end
			S_LN_EV: begin
				if (is_term(fifo_rd))
					term_q <= fifo_rd;
				else if (is_bs(fifo_rd)) begin
					if (n_q != '0)
						n_q <= LINE_AW'(n_q - 1'b1);
				end else
					n_q <= LINE_AW'(n_q + 1'b1);
			end
			S_EM_OUT: begin
				if (out_free)
					k_q <= LINE_AW'(k_q + 1'b1);
			end
			default: ;
		endcase
	end

	// result register; fifo status is final once a result is loaded
	always_ff @(posedge clk) begin
		if (load_single) begin
			echo_byte_q   <= echo_v_q ? rx_q : 8'h00;
			echo_valid_q  <= echo_v_q;
			dropped_q     <= drop_q;
			data_byte_q   <= data_q;
			data_valid_q  <= dvalid_q;
			line_length_q <= '0;
			last_q        <= 1'b1;
			has_data_q    <= !fsts.empty;
			has_line_q    <= fsts.has_line;
		end else if (load_line) begin
			echo_byte_q   <= 8'h00;
			echo_valid_q  <= 1'b0;
			dropped_q     <= 1'b0;
			data_byte_q   <= line_rd;
			data_valid_q  <= 1'b1;
			line_length_q <= n_q;
			last_q        <= em_last;
			has_data_q    <= !fsts.empty;
			has_line_q    <= fsts.has_line;
		end
	end

	assign out_valid   = out_valid_q;
	assign echo_byte   = echo_byte_q;
	assign echo_valid  = echo_valid_q;
	assign dropped     = dropped_q;
	assign data_byte   = data_byte_q;
	assign data_valid  = data_valid_q;
	assign line_length = line_length_q;
	assign last        = last_q;
	assign has_data    = has_data_q;
	assign has_line    = has_line_q;

`ifndef NO_ASSERTIONS
	a_drop_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> echo_valid)
		else $error("dropped result without echo");

	a_line_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_length != '0 |-> data_valid && !echo_valid)
		else $error("line result without a character");

	a_line_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> !has_line)
		else $error("terminator reported in an empty fifo");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EM_OUT |-> k_q < n_q)
		else $error("line emission past its length");
`endif

endmodule
